### hw/rtl/sdf_pkg.sv
// shared types and constants for the signed decimal formatter
`default_nettype none

package sdf_pkg;

	// datapath operation selected by the current control word
	typedef enum logic [2:0] {
		OP_ACCEPT,
		OP_MUL,
		OP_DIV,
		OP_FIX,
		OP_SIGN,
		OP_PAD,
		OP_DIGIT
	} op_t;

	// how the step counter moves after the current step
	typedef enum logic [1:0] {
		COND_GO,
		COND_WAIT,
		COND_BRANCH
	} cond_t;

	localparam int PC_W      = 3;
	localparam int NUM_STEPS = 2 ** PC_W;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} ctl_t;

	typedef struct packed {
		logic go;
		logic qnz;
	} stat_t;

	localparam int NUM_DIGITS = 10;
	localparam int ND_W       = 4;

	// quotient by ten through the reciprocal, exact for every 32-bit magnitude
	localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;
	localparam int          QUOT_W      = 64 - RECIP_SHIFT;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;

endpackage

`default_nettype wire

### hw/rtl/sdf_in_if.sv
// operand channel: integer with precision and sign flags
`default_nettype none

interface sdf_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic signed [6:0]  precision;
	logic               show_plus;
	logic               show_space;

	modport source (output valid, value, precision, show_plus, show_space, input ready);
	modport sink (input valid, value, precision, show_plus, show_space, output ready);
endinterface

`default_nettype wire

### hw/rtl/sdf_out_if.sv
// text channel: one character per transfer
`default_nettype none

interface sdf_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  character;
	logic        last;
	logic [31:0] running_total;

	modport source (output valid, character, last, running_total, input ready);
	modport sink (input valid, character, last, running_total, output ready);
endinterface

`default_nettype wire

### hw/rtl/sdf_sequencer.sv
// microcode rom and step counter
`default_nettype none

module sdf_sequencer
	import sdf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctl_t  ctl
);

	localparam logic [PC_W-1:0] STEP_ACCEPT = PC_W'(0);
	localparam logic [PC_W-1:0] STEP_MUL    = PC_W'(1);
	localparam logic [PC_W-1:0] STEP_DIV    = PC_W'(2);
	localparam logic [PC_W-1:0] STEP_SIGN   = PC_W'(4);
	localparam logic [PC_W-1:0] STEP_PAD    = PC_W'(5);
	localparam logic [PC_W-1:0] STEP_DIGIT  = PC_W'(6);

	localparam ctl_t PROGRAM [NUM_STEPS] = '{
		'{op: OP_ACCEPT, cond: COND_WAIT,   target: STEP_MUL},
		'{op: OP_MUL,    cond: COND_GO,     target: STEP_DIV},
		// loop on digits while the quotient is nonzero, else fall through to fix
		'{op: OP_DIV,    cond: COND_BRANCH, target: STEP_MUL},
		'{op: OP_FIX,    cond: COND_GO,     target: STEP_SIGN},
		'{op: OP_SIGN,   cond: COND_WAIT,   target: STEP_PAD},
		'{op: OP_PAD,    cond: COND_WAIT,   target: STEP_DIGIT},
		'{op: OP_DIGIT,  cond: COND_WAIT,   target: STEP_ACCEPT},
		'{op: OP_ACCEPT, cond: COND_GO,     target: STEP_ACCEPT}
	};

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;

	always_comb begin
		ctl = PROGRAM[pc_q];
		case (ctl.cond)
			COND_GO:     pc_next = ctl.target;
			COND_WAIT:   pc_next = stat.go ? ctl.target : pc_q;
			COND_BRANCH: pc_next = stat.qnz ? ctl.target : pc_q + PC_W'(1);
			default:     pc_next = STEP_ACCEPT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_ACCEPT;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/sdf_datapath.sv
// digit extraction, padding and character output datapath
`default_nettype none

module sdf_datapath
	import sdf_pkg::*;
#(
	parameter int MAX_PRECISION = 63,
	parameter int PREC_W        = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	input  ctl_t         ctl,
	output stat_t        stat,
	sdf_in_if.sink       operand,
	sdf_out_if.source    text
);

	logic [31:0]       mag_q;
	logic              neg_q;
	logic              plus_q;
	logic              zero_q;
	logic              nopad_q;
	logic [PREC_W-1:0] prec_q;
	logic [QUOT_W-1:0] quot_q;
	logic [3:0]        digit_q [NUM_DIGITS];
	logic [ND_W-1:0]   nd_q;
	logic [PREC_W-1:0] pad_q;
	logic              sign_q;
	logic              out_valid_q;
	logic [7:0]        char_q;
	logic              last_q;
	logic [31:0]       total_q;

	logic              in_xfer;
	logic [31:0]       in_mag;
	logic [PREC_W-1:0] in_prec;
	logic [63:0]       prod;
	logic [31:0]       quot_ext;
	logic [31:0]       rem;
	logic [ND_W-1:0]   nd_fix;
	logic [PREC_W-1:0] nd_wide;
	logic              slot_free;
	logic              rem_nz;
	logic              rem_one;
	logic              fire;
	logic [7:0]        ch;
	logic              ch_last;

	assign operand.ready = (ctl.op == OP_ACCEPT);
	assign in_xfer       = operand.valid && operand.ready;
	assign in_mag        = operand.value[31] ? (32'd0 - operand.value) : operand.value;
	assign in_prec = (7'(operand.precision[5:0]) > 7'(MAX_PRECISION)) ?
		PREC_W'(MAX_PRECISION) : PREC_W'(operand.precision[5:0]);

	assign prod     = {32'd0, mag_q} * {32'd0, RECIP};
	assign quot_ext = 32'(quot_q);
	assign rem      = mag_q - ((quot_ext << 3) + (quot_ext << 1));

	// zero with precision zero prints no digits
	assign nd_fix  = (zero_q && !nopad_q && prec_q == '0) ? '0 : nd_q;
	assign nd_wide = PREC_W'(nd_fix);

	assign slot_free = !out_valid_q || text.ready;

	always_comb begin
		rem_nz  = 1'b0;
		rem_one = 1'b0;
		ch      = CH_ZERO;
		ch_last = 1'b0;
		case (ctl.op)
			OP_SIGN: begin
				rem_nz  = sign_q;
				rem_one = sign_q;
				ch      = neg_q ? CH_MINUS : (plus_q ? CH_PLUS : CH_SPACE);
				ch_last = (pad_q == '0) && (nd_q == '0);
			end
			OP_PAD: begin
				rem_nz  = (pad_q != '0);
				rem_one = (pad_q == PREC_W'(1));
				ch_last = (pad_q == PREC_W'(1)) && (nd_q == '0);
			end
			OP_DIGIT: begin
				rem_nz  = (nd_q != '0);
				rem_one = (nd_q == ND_W'(1));
				ch      = CH_ZERO + 8'(digit_q[nd_q - ND_W'(1)]);
				ch_last = (nd_q == ND_W'(1));
			end
			default: begin
				rem_nz = 1'b0;
			end
		endcase
	end

	assign fire = slot_free && rem_nz;

	always_comb begin
		case (ctl.op)
			OP_ACCEPT: stat.go = in_xfer;
			OP_SIGN,
			OP_PAD,
			OP_DIGIT:  stat.go = !rem_nz || (fire && rem_one);
			default:   stat.go = 1'b1;
		endcase
		stat.qnz = (quot_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q        <= '0;
			pad_q       <= '0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			if (in_xfer) begin
				nd_q   <= '0;
				pad_q  <= '0;
				sign_q <= operand.value[31] || operand.show_plus || operand.show_space;
			end
			if (ctl.op == OP_DIV) begin
				nd_q <= nd_q + ND_W'(1);
			end
			if (ctl.op == OP_FIX) begin
				nd_q  <= nd_fix;
				pad_q <= (!nopad_q && prec_q > nd_wide) ? prec_q - nd_wide : '0;
			end
			if (fire) begin
				total_q <= total_q + 32'd1;
				case (ctl.op)
					OP_SIGN:  sign_q <= 1'b0;
					OP_PAD:   pad_q  <= pad_q - PREC_W'(1);
					OP_DIGIT: nd_q   <= nd_q - ND_W'(1);
					default:  sign_q <= sign_q;
				endcase
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mag_q   <= in_mag;
			neg_q   <= operand.value[31];
			plus_q  <= operand.show_plus;
			zero_q  <= (operand.value == '0);
			nopad_q <= operand.precision[6];
			prec_q  <= in_prec;
		end
		if (ctl.op == OP_MUL) begin
			quot_q <= prod[63:RECIP_SHIFT];
		end
		if (ctl.op == OP_DIV) begin
			digit_q[nd_q] <= rem[3:0];
			mag_q         <= quot_ext;
		end
		if (fire) begin
			char_q <= ch;
			last_q <= ch_last;
		end
	end

	assign text.valid         = out_valid_q;
	assign text.character     = char_q;
	assign text.last          = last_q;
	assign text.running_total = total_q;

endmodule

`default_nettype wire

### hw/rtl/signed_decimal_formatter_unit.sv
// Signed decimal formatter: turns a 32-bit integer into ASCII text.
// operand channel (sink): value, precision, show_plus, show_space. An item
// transfers when valid and ready are high; ready is high only while the
// unit waits for a new item.
// text channel (source): one character per transfer, last marks the end of
// an item's run, running_total counts characters since reset (wraps at 2^32).
// A microcoded sequencer steps a datapath: a step to take the item, a
// reciprocal multiply step and a remainder step per decimal digit, a step to
// size padding, then one character per cycle while the receiver does not
// stall; the sign, padding and digit steps are still visited when they have
// nothing to send. An item has 1..10 decimal digits. The output register
// holds a character while the receiver stalls, and the sequencer waits on it.
// An item with zero value, precision zero and no sign produces no transfer.
// Reset clears the running total, the output valid and the step counter.
`default_nettype none

module signed_decimal_formatter_unit
	import sdf_pkg::*;
#(
	parameter int MAX_PRECISION = 63
) (
	input  wire       clk,
	input  wire       arst_n,
	sdf_in_if.sink    operand,
	sdf_out_if.source text
);

	localparam int PREC_W = $clog2(MAX_PRECISION + 1);

	ctl_t  ctl;
	stat_t stat;

	sdf_sequencer u_sequencer (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	sdf_datapath #(
		.MAX_PRECISION (MAX_PRECISION),
		.PREC_W        (PREC_W)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.stat    (stat),
		.operand (operand),
		.text    (text)
	);

`ifndef NO_ASSERTIONS
	// an accepted item always starts digit extraction
	a_accept_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(operand.valid && operand.ready) |=> (ctl.op == OP_MUL))
		else $error("sequencer did not start digit extraction");

	// no character can appear right after an item is taken
	a_no_early_char: assert property (@(posedge clk) disable iff (!arst_n)
		(operand.valid && operand.ready) |=> !$rose(text.valid))
		else $error("character produced before any digit was computed");

	// while a non-final character transfers the run is still in progress
	a_run_in_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && text.ready && !text.last) |-> (ctl.op != OP_ACCEPT))
		else $error("new item accepted before the run ended");
`endif

endmodule

`default_nettype wire
